>>> sv/toiir_pkg.sv
// ----------------------------------------------------------------------------
// toiir_pkg
// Widths, fixed-point formats and coefficients of the third-order low-pass.
// ----------------------------------------------------------------------------
package toiir_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int FRAC_W    = 24;
   localparam int HIST_W    = SAMPLE_W + FRAC_W;
   localparam int COEF_W    = 32;
   localparam int COEF_FRAC = 29;
   localparam int TAPS      = 3;

   // feedback products are the widest terms, plus headroom for six terms
   localparam int FB_PROD_W = HIST_W + COEF_W;
   localparam int FF_PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W     = FB_PROD_W + 3;
   localparam int SHR_W     = ACC_W - COEF_FRAC;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [HIST_W-1:0]   hist_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   typedef struct packed {
      hist_type   y;
      sample_type sample;
      logic       sat;
   } step_result_type;

   // Q3.29, rounded to nearest
   localparam coef_type FF_COEF [TAPS] = '{32'sd80906, 32'sd304674, 32'sd71726};
   localparam coef_type FB_COEF [TAPS] = '{32'sd1484448072, -32'sd1370094567,
                                            32'sd422302659};

endpackage

>>> sv/toiir_step.sv
// ----------------------------------------------------------------------------
// toiir_step
// One filter update: sum of products on the histories, rounding to the state
// format, saturation, and rounding/saturation to the sample width.
// ----------------------------------------------------------------------------
module toiir_step import toiir_pkg::*; (
   input  sample_type      x_hist [TAPS],
   input  hist_type        y_hist [TAPS],
   output step_result_type result
);

   logic signed [FF_PROD_W-1:0] ff_prod [TAPS];
   logic signed [FB_PROD_W-1:0] fb_prod [TAPS];
   logic signed [ACC_W-1:0]     acc;
   logic signed [ACC_W-1:0]     acc_rnd;
   logic signed [SHR_W-1:0]     acc_shr;
   logic                        hist_sat;
   hist_type                    y_new;
   logic signed [HIST_W:0]      out_rnd;
   logic signed [SAMPLE_W:0]    out_shr;
   logic                        out_sat;
   sample_type                  out_val;

   localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [HIST_W:0]   OUT_HALF = (HIST_W + 1)'(1) <<< (FRAC_W - 1);
   localparam hist_type   HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
   localparam hist_type   HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
   localparam sample_type SMP_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SMP_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

   always_comb begin
      acc = '0;
      for (int i = 0; i < TAPS; i++) begin
         ff_prod[i] = x_hist[i] * FF_COEF[i];
         fb_prod[i] = y_hist[i] * FB_COEF[i];
         acc = acc + (ACC_W'(ff_prod[i]) <<< FRAC_W) + ACC_W'(fb_prod[i]);
      end

      // round to nearest, ties up, then drop the coefficient fraction
      acc_rnd = acc + ACC_HALF;
      acc_shr = acc_rnd[ACC_W-1:COEF_FRAC];

      // bits above the history width must all match the sign
      hist_sat = (acc_shr[SHR_W-1:HIST_W-1] != {(SHR_W-HIST_W+1){1'b0}}) &&
                 (acc_shr[SHR_W-1:HIST_W-1] != {(SHR_W-HIST_W+1){1'b1}});
      if (hist_sat) begin
         y_new = acc_shr[SHR_W-1] ? HIST_MIN : HIST_MAX;
      end else begin
         y_new = acc_shr[HIST_W-1:0];
      end

      out_rnd = (HIST_W + 1)'(y_new) + OUT_HALF;
      out_shr = out_rnd[HIST_W:FRAC_W];
      out_sat = out_shr[SAMPLE_W] != out_shr[SAMPLE_W-1];
      if (out_sat) begin
         out_val = out_shr[SAMPLE_W] ? SMP_MIN : SMP_MAX;
      end else begin
         out_val = out_shr[SAMPLE_W-1:0];
      end

      result.y      = y_new;
      result.sample = out_val;
      result.sat    = hist_sat | out_sat;
   end

endmodule

>>> sv/third_order_iir_lowpass_core.sv
// ----------------------------------------------------------------------------
// third_order_iir_lowpass_core: third-order recursive low-pass filter
// The response is registered and valid in the cycle after a request is taken;
// one request per cycle while rsp_ready holds, limited by the feedback loop.
// Synchronous reset clears both histories and the response valid.
// ----------------------------------------------------------------------------
module third_order_iir_lowpass_core import toiir_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_filtered_sample,
   output logic       rsp_saturated
);

   sample_type      x_hist_ff [TAPS];
   hist_type        y_hist_ff [TAPS];
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   sample_type      rsp_sample_ff;
   logic            rsp_sat_ff;
   step_result_type step;
   logic            req_take;

   toiir_step u_step (
      .x_hist (x_hist_ff),
      .y_hist (y_hist_ff),
      .result (step)
   );

   // the output register frees up in the same cycle it is read
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_take     = req_valid && req_ready;
   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TAPS; i++) begin
            x_hist_ff[i] <= '0;
            y_hist_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            x_hist_ff[0] <= req_sample;
            y_hist_ff[0] <= step.y;
            for (int i = 1; i < TAPS; i++) begin
               x_hist_ff[i] <= x_hist_ff[i-1];
               y_hist_ff[i] <= y_hist_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_sample_ff <= step.sample;
         rsp_sat_ff    <= step.sat;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_saturated       = rsp_sat_ff;

`ifndef SYNTHESIS
   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while response stalled");

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_filtered_sample == {1'b0, {(SAMPLE_W-1){1'b1}}}) ||
         (rsp_filtered_sample == {1'b1, {(SAMPLE_W-1){1'b0}}}))
      else $error("saturation flagged on an output away from the rails");

   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> x_hist_ff[0] == $past(req_sample))
      else $error("input history not updated with accepted sample");
`endif

endmodule
